>>> design/lcd_pkg.sv
// Shared types, codes and reset values for the lasso coordinate descent block.
package lcd_pkg;

    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_COLS_DEF = 16;
    localparam int NCOEF        = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [1:0] OP_MAT = 2'd0;
    localparam logic [1:0] OP_TGT = 2'd1;
    localparam logic [1:0] OP_RUN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 3'd4;

    localparam logic [30:0] LAMBDA_RST    = 31'd65536;
    localparam logic [30:0] TOLERANCE_RST = 31'd7;
    localparam logic [15:0] MAX_ITER_RST  = 16'd1000;
    localparam logic [10:0] ROW_COUNT_RST = 11'd1024;
    localparam logic [4:0]  COL_COUNT_RST = 5'd16;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic               last;
        logic [15:0]        sweeps_used;
        logic               converged;
    } t_out_item;

endpackage

>>> design/lasso_coordinate_descent.sv
// Top level of the lasso fit engine: load storage, coordinate descent sequencer, result port.
//
// Usage. An item is taken at a rising edge with start high and busy low.
// Opcode 0 writes one design matrix entry, opcode 1 one target entry; both
// are stored at once, cause no result and keep busy low, so between fits loads
// stream at one item per cycle. Opcode 2 runs a fit: busy rises on the next cycle and
// stays high until the last coefficient is shown. Opcode 3 is ignored.
// Results appear on o_res for one cycle each, marked by o_res_valid, for
// coefficient 0 up to p-1 in consecutive cycles; last marks the final one,
// and busy is already low in that cycle. The receiver cannot stall.
// A fit with N rows, p columns and S sweeps first clears the prediction
// memory, then per column of each sweep runs the correlation pass, the shared
// bit-serial divider with the numerator and check steps (without the quotient
// division when the energy or numerator is zero), a second row pass when
// the coefficient moves and the change update; then p results are output.
// Each row pass reads one row at a time through the single read port of the
// matrix and prediction memories.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data, by the user only
// while idle; the block itself does not enforce it. Reset restores the register defaults
// and zeroes the coefficients; stored matrix and target data are undefined until written.
module lasso_coordinate_descent #(
    parameter int MAX_ROWS = lcd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lcd_pkg::MAX_COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  lcd_pkg::t_in_item                 i_item,
    input  logic                              i_cfg_we,
    input  logic [lcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_res_valid,
    output lcd_pkg::t_out_item                o_res
);
    import lcd_pkg::*;

    localparam int RAW   = $clog2(MAX_ROWS);
    localparam int NW    = $clog2(MAX_ROWS + 1);
    localparam int MDEP  = MAX_ROWS * MAX_COLS;
    localparam int MAW   = $clog2(MDEP);
    localparam int DIV_W = 80;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_COLSTART = 4'd2;
    localparam logic [3:0] ST_COLA     = 4'd3;
    localparam logic [3:0] ST_DRAINA   = 4'd4;
    localparam logic [3:0] ST_DIVZ     = 4'd5;
    localparam logic [3:0] ST_DIVR     = 4'd6;
    localparam logic [3:0] ST_NUM      = 4'd7;
    localparam logic [3:0] ST_DIVQ     = 4'd8;
    localparam logic [3:0] ST_NBCHK    = 4'd9;
    localparam logic [3:0] ST_COLB     = 4'd10;
    localparam logic [3:0] ST_DRAINB   = 4'd11;
    localparam logic [3:0] ST_CHG1     = 4'd12;
    localparam logic [3:0] ST_CHG2     = 4'd13;
    localparam logic [3:0] ST_OUT      = 4'd14;

    function automatic logic signed [63:0] f_trunc16(input logic signed [63:0] a);
        logic signed [63:0] b;
        b = a + (a[63] ? 64'sd65535 : 64'sd0);
        return b >>> 16;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [64:0] a);
        logic fits;
        fits = (&a[64:31]) || !(|a[64:31]);
        if (fits) begin
            return a[31:0];
        end
        return a[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // Configuration registers.
    logic [30:0] r_lambda;
    logic [30:0] r_tol;
    logic [15:0] r_max_iter;
    logic [10:0] r_row_count;
    logic [4:0]  r_col_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda    <= LAMBDA_RST;
            r_tol       <= TOLERANCE_RST;
            r_max_iter  <= MAX_ITER_RST;
            r_row_count <= ROW_COUNT_RST;
            r_col_count <= COL_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LAMBDA:    r_lambda    <= i_cfg_data[30:0];
                CFG_TOLERANCE: r_tol       <= i_cfg_data[30:0];
                CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[15:0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[10:0];
                CFG_COL_COUNT: r_col_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Control and datapath registers.
    logic [3:0]          r_state;
    logic [NW-1:0]       r_n;
    logic [4:0]          r_p;
    logic [RAW-1:0]      r_row;
    logic [3:0]          r_j;
    logic [3:0]          r_k;
    logic [15:0]         r_sweeps;
    logic                r_conv;
    logic                r_pass_b;
    logic [4:1]          r_v;
    logic signed [31:0]  r_coef [NCOEF];
    logic signed [31:0]  r_bj;
    logic signed [31:0]  r_nb;
    logic signed [63:0]  r_zs;
    logic signed [63:0]  r_rs;
    logic [63:0]         r_z;
    logic signed [63:0]  r_rho;
    logic                r_rs_neg;
    logic                r_num_neg;
    logic [63:0]         r_change;
    logic [63:0]         r_chg_prod;
    logic [63:0]         r_div_rem;
    logic [DIV_W-1:0]    r_div_quo;
    logic [63:0]         r_div_den;
    logic [6:0]          r_div_cnt;
    logic                r_out_valid;
    t_out_item           r_out;

    // Pipeline payload registers.
    logic [RAW-1:0]      r_s1_row;
    logic [RAW-1:0]      r_s2_row;
    logic signed [63:0]  r_s2_pxb;
    logic signed [63:0]  r_s2_pxn;
    logic signed [31:0]  r_s2_x;
    logic signed [31:0]  r_s2_t;
    logic signed [63:0]  r_s2_pred;
    logic signed [31:0]  r_s3_x;
    logic signed [31:0]  r_s3_r;
    logic signed [63:0]  r_s4_xx;
    logic signed [63:0]  r_s4_xr;

    // Memory ports.
    logic                w_accept;
    logic                w_mat_we;
    logic                w_tgt_we;
    logic [31:0]         w_mat_wa32;
    logic [31:0]         w_tgt_wa32;
    logic [31:0]         w_mat_ra32;
    logic [31:0]         w_mat_rdata;
    logic [31:0]         w_tgt_rdata;
    logic [63:0]         w_pred_rdata;
    logic                w_pred_we;
    logic [RAW-1:0]      w_pred_wa;
    logic [63:0]         w_pred_wd;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    assign w_mat_wa32 = 32'(i_item.row) * 32'(MAX_COLS) + 32'(i_item.col);
    assign w_tgt_wa32 = 32'(i_item.row);
    assign w_mat_we   = w_accept && (i_item.opcode == OP_MAT)
                        && (32'(i_item.row) < 32'(MAX_ROWS))
                        && (32'(i_item.col) < 32'(MAX_COLS));
    assign w_tgt_we   = w_accept && (i_item.opcode == OP_TGT)
                        && (32'(i_item.row) < 32'(MAX_ROWS));
    assign w_mat_ra32 = 32'(r_row) * 32'(MAX_COLS) + 32'(r_j);

    lcd_ram #(.WIDTH(32), .DEPTH(MDEP)) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (w_mat_we),
        .i_waddr (w_mat_wa32[MAW-1:0]),
        .i_wdata (i_item.value),
        .i_raddr (w_mat_ra32[MAW-1:0]),
        .o_rdata (w_mat_rdata)
    );

    lcd_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_tgt_we),
        .i_waddr (w_tgt_wa32[RAW-1:0]),
        .i_wdata (i_item.value),
        .i_raddr (r_row),
        .o_rdata (w_tgt_rdata)
    );

    lcd_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_pred_ram (
        .i_clk   (i_clk),
        .i_we    (w_pred_we),
        .i_waddr (w_pred_wa),
        .i_wdata (w_pred_wd),
        .i_raddr (r_row),
        .o_rdata (w_pred_rdata)
    );

    // Clamped run sizes.
    logic [31:0] w_n32;
    logic [31:0] w_p32;
    always_comb begin
        priority if (r_row_count == 11'd0) begin
            w_n32 = 32'd1;
        end else if (32'(r_row_count) > 32'(MAX_ROWS)) begin
            w_n32 = 32'(MAX_ROWS);
        end else begin
            w_n32 = 32'(r_row_count);
        end
        priority if (r_col_count == 5'd0) begin
            w_p32 = 32'd1;
        end else if (32'(r_col_count) > 32'(MAX_COLS) && MAX_COLS <= NCOEF) begin
            w_p32 = 32'(MAX_COLS);
        end else if (32'(r_col_count) > 32'(NCOEF)) begin
            w_p32 = 32'(NCOEF);
        end else begin
            w_p32 = 32'(r_col_count);
        end
    end

    logic [RAW-1:0] w_last_row;
    logic           w_row_end;
    assign w_last_row = RAW'(r_n - NW'(1));
    assign w_row_end  = (r_row == w_last_row);

    // Row pipeline: stage 1 has the memory data, stage 4 accumulates.
    logic signed [31:0] w_x;
    logic signed [31:0] w_t;
    logic signed [63:0] w_pred;
    logic signed [63:0] w_others;
    logic signed [64:0] w_diff;
    logic signed [63:0] w_pred_new;
    logic               w_issue;

    assign w_x      = w_mat_rdata;
    assign w_t      = w_tgt_rdata;
    assign w_pred   = w_pred_rdata;
    assign w_issue  = (r_state == ST_COLA) || (r_state == ST_COLB);
    assign w_others = r_s2_pred - f_trunc16(r_s2_pxb);
    assign w_diff   = {{33{r_s2_t[31]}}, r_s2_t} - {w_others[63], w_others};
    assign w_pred_new = r_s2_pred + f_trunc16(r_s2_pxn) - f_trunc16(r_s2_pxb);

    assign w_pred_we = (r_state == ST_CLEAR) || (r_v[2] && r_pass_b);
    assign w_pred_wa = (r_state == ST_CLEAR) ? r_row : r_s2_row;
    assign w_pred_wd = (r_state == ST_CLEAR) ? 64'd0 : w_pred_new;

    always_ff @(posedge i_clk) begin
        r_s1_row  <= r_row;
        r_s2_row  <= r_s1_row;
        r_s2_pxb  <= w_x * r_bj;
        r_s2_pxn  <= w_x * r_nb;
        r_s2_x    <= w_x;
        r_s2_t    <= w_t;
        r_s2_pred <= w_pred;
        r_s3_x    <= r_s2_x;
        r_s3_r    <= f_sat32(w_diff);
        r_s4_xx   <= r_s3_x * r_s3_x;
        r_s4_xr   <= r_s3_x * r_s3_r;
    end

    // Shared restoring divider, one quotient bit per cycle.
    logic [64:0] w_div_sh;
    logic [64:0] w_div_sub;
    logic        w_div_ge;
    logic        w_div_run;
    logic        w_div_done;
    assign w_div_sh   = {r_div_rem, r_div_quo[DIV_W-1]};
    assign w_div_sub  = w_div_sh - {1'b0, r_div_den};
    assign w_div_ge   = (w_div_sh >= {1'b0, r_div_den});
    assign w_div_done = (r_div_cnt == 7'(DIV_W));
    assign w_div_run  = ((r_state == ST_DIVZ) || (r_state == ST_DIVR)
                        || (r_state == ST_DIVQ)) && !w_div_done;

    // Numerator, signed results and change terms.
    logic signed [63:0] w_lam;
    logic signed [63:0] w_num;
    logic signed [63:0] w_num_neg;
    logic [63:0]        w_num_mag;
    logic signed [63:0] w_rs_neg;
    logic [63:0]        w_rs_mag;
    logic signed [63:0] w_quo64;
    logic signed [31:0] w_q31;
    logic signed [31:0] w_qsat;
    logic signed [32:0] w_ddiff;
    logic signed [32:0] w_dneg;
    logic [31:0]        w_dmag;
    logic [63:0]        w_chg_new;
    logic               w_col_last;
    logic               w_out_last;

    assign w_lam = {33'd0, r_lambda};
    always_comb begin
        priority if (r_j == 4'd0) begin
            w_num = r_rho;
        end else if (r_rho > w_lam) begin
            w_num = r_rho - w_lam;
        end else if (r_rho < -w_lam) begin
            w_num = r_rho + w_lam;
        end else begin
            w_num = 64'sd0;
        end
    end
    assign w_num_neg = -w_num;
    assign w_num_mag = w_num[63] ? w_num_neg : w_num;
    assign w_rs_neg  = -r_rs;
    assign w_rs_mag  = r_rs[63] ? w_rs_neg : r_rs;
    assign w_quo64   = r_div_quo[63:0];
    assign w_q31     = {1'b0, r_div_quo[30:0]};
    always_comb begin
        if (|r_div_quo[DIV_W-1:31]) begin
            w_qsat = r_num_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_qsat = r_num_neg ? -w_q31 : w_q31;
        end
    end
    assign w_ddiff    = {r_nb[31], r_nb} - {r_bj[31], r_bj};
    assign w_dneg     = -w_ddiff;
    assign w_dmag     = w_ddiff[32] ? w_dneg[31:0] : w_ddiff[31:0];
    assign w_chg_new  = r_change + {16'd0, r_chg_prod[63:16]};
    assign w_col_last = ({1'b0, r_j} == (r_p - 5'd1));
    assign w_out_last = ({1'b0, r_k} == (r_p - 5'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_v         <= '0;
            r_out_valid <= 1'b0;
            r_coef      <= '{default: '0};
            r_sweeps    <= '0;
            r_conv      <= 1'b0;
            r_pass_b    <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            r_out_valid <= (r_state == ST_OUT);
            r_v[1] <= w_issue;
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2] && !r_pass_b;
            r_v[4] <= r_v[3];
            if (r_v[4]) begin
                r_zs <= r_zs + f_trunc16(r_s4_xx);
                r_rs <= r_rs + f_trunc16(r_s4_xr);
            end
            if (w_div_run) begin
                r_div_rem <= w_div_ge ? w_div_sub[63:0] : w_div_sh[63:0];
                r_div_quo <= {r_div_quo[DIV_W-2:0], w_div_ge};
                r_div_cnt <= r_div_cnt + 7'd1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (start && i_item.opcode == OP_RUN) begin
                        r_n      <= w_n32[NW-1:0];
                        r_p      <= w_p32[4:0];
                        r_coef   <= '{default: '0};
                        r_sweeps <= '0;
                        r_conv   <= 1'b0;
                        r_row    <= '0;
                        r_state  <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    if (w_row_end) begin
                        r_row <= '0;
                        if (r_max_iter == 16'd0) begin
                            r_k     <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_j      <= '0;
                            r_change <= '0;
                            r_state  <= ST_COLSTART;
                        end
                    end else begin
                        r_row <= r_row + RAW'(1);
                    end
                end
                ST_COLSTART: begin
                    r_bj     <= r_coef[r_j];
                    r_zs     <= '0;
                    r_rs     <= '0;
                    r_row    <= '0;
                    r_pass_b <= 1'b0;
                    r_state  <= ST_COLA;
                end
                ST_COLA: begin
                    if (w_row_end) begin
                        r_state <= ST_DRAINA;
                    end else begin
                        r_row <= r_row + RAW'(1);
                    end
                end
                ST_DRAINA: begin
                    if (r_v == '0) begin
                        r_div_rem <= '0;
                        r_div_quo <= {16'd0, r_zs};
                        r_div_den <= 64'(r_n);
                        r_div_cnt <= '0;
                        r_state   <= ST_DIVZ;
                    end
                end
                ST_DIVZ: begin
                    if (w_div_done) begin
                        r_z       <= r_div_quo[63:0];
                        r_rs_neg  <= r_rs[63];
                        r_div_rem <= '0;
                        r_div_quo <= {16'd0, w_rs_mag};
                        r_div_den <= 64'(r_n);
                        r_div_cnt <= '0;
                        r_state   <= ST_DIVR;
                    end
                end
                ST_DIVR: begin
                    if (w_div_done) begin
                        r_rho   <= r_rs_neg ? -w_quo64 : w_quo64;
                        r_state <= ST_NUM;
                    end
                end
                ST_NUM: begin
                    if (r_z == 64'd0 || w_num == 64'sd0) begin
                        r_nb    <= '0;
                        r_state <= ST_NBCHK;
                    end else begin
                        r_num_neg <= w_num[63];
                        r_div_rem <= '0;
                        r_div_quo <= {w_num_mag, 16'd0};
                        r_div_den <= r_z;
                        r_div_cnt <= '0;
                        r_state   <= ST_DIVQ;
                    end
                end
                ST_DIVQ: begin
                    if (w_div_done) begin
                        r_nb    <= w_qsat;
                        r_state <= ST_NBCHK;
                    end
                end
                ST_NBCHK: begin
                    if (r_nb != r_bj) begin
                        r_row    <= '0;
                        r_pass_b <= 1'b1;
                        r_state  <= ST_COLB;
                    end else begin
                        r_state <= ST_CHG1;
                    end
                end
                ST_COLB: begin
                    if (w_row_end) begin
                        r_state <= ST_DRAINB;
                    end else begin
                        r_row <= r_row + RAW'(1);
                    end
                end
                ST_DRAINB: begin
                    if (r_v == '0) begin
                        r_state <= ST_CHG1;
                    end
                end
                ST_CHG1: begin
                    r_chg_prod <= 64'(w_dmag) * 64'(w_dmag);
                    r_state    <= ST_CHG2;
                end
                ST_CHG2: begin
                    r_coef[r_j] <= r_nb;
                    if (w_col_last) begin
                        r_sweeps <= r_sweeps + 16'd1;
                        if (w_chg_new < {33'd0, r_tol}) begin
                            r_conv  <= 1'b1;
                            r_k     <= '0;
                            r_state <= ST_OUT;
                        end else if (r_sweeps + 16'd1 == r_max_iter) begin
                            r_k     <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_j      <= '0;
                            r_change <= '0;
                            r_state  <= ST_COLSTART;
                        end
                    end else begin
                        r_j      <= r_j + 4'd1;
                        r_change <= w_chg_new;
                        r_state  <= ST_COLSTART;
                    end
                end
                ST_OUT: begin
                    r_out.coef_index <= r_k;
                    r_out.coef_value <= r_coef[r_k];
                    r_out.last       <= w_out_last;
                    r_out.sweeps_used <= r_sweeps;
                    r_out.converged  <= r_conv;
                    if (w_out_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

>>> design/lcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lcd_checker.sv
// Port-level checker for the lasso fit engine, bound to the top level.
module lcd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input lcd_pkg::t_in_item  i_item,
    input logic               o_res_valid,
    input lcd_pkg::t_out_item o_res
);
    import lcd_pkg::*;

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.opcode == OP_RUN |=> busy)
        else $error("run item did not raise busy");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |=> o_res_valid
            && o_res.coef_index == 4'($past(o_res.coef_index) + 4'd1))
        else $error("result burst broken or out of order");

    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !$past(o_res_valid) |-> o_res.coef_index == 4'd0)
        else $error("result burst does not start at coefficient zero");

    a_busy_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy == !o_res.last)
        else $error("busy does not match position in result burst");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |=> $stable(o_res.sweeps_used)
            && $stable(o_res.converged))
        else $error("run status changed within a result burst");

endmodule

bind lasso_coordinate_descent lcd_checker u_lcd_checker (.*);

>>> sim/lasso_coordinate_descent_test.sv
// Self-checking testbench for the lasso coordinate descent block.
`timescale 1ns / 1ps

module lasso_coordinate_descent_test;
    import lcd_pkg::*;

    localparam logic [1:0]           OP_NONE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    // Predicts the coefficients of each fit and checks the result stream.
    class fit_scoreboard;
        int        mat_mem[16384];
        int        tgt_mem[1024];
        bit [30:0] lambda_q;
        bit [30:0] tol_q;
        bit [15:0] iter_max;
        bit [10:0] rows_cfg;
        bit [4:0]  cols_cfg;
        t_out_item coef_expect_q[$];
        int        errors;

        function new();
            foreach (mat_mem[i]) mat_mem[i] = 0;
            foreach (tgt_mem[i]) tgt_mem[i] = 0;
            lambda_q = LAMBDA_RST;
            tol_q    = TOLERANCE_RST;
            iter_max = MAX_ITER_RST;
            rows_cfg = ROW_COUNT_RST;
            cols_cfg = COL_COUNT_RST;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LAMBDA:    lambda_q = data;
                CFG_TOLERANCE: tol_q    = data;
                CFG_MAX_ITER:  iter_max = data[15:0];
                CFG_ROW_COUNT: rows_cfg = data[10:0];
                CFG_COL_COUNT: cols_cfg = data[4:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return coef_expect_q.size();
        endfunction

        function longint qmul(int a, int b);
            return (longint'(a) * longint'(b)) / 64'sd65536;
        endfunction

        function int sat32(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return int'(v);
        endfunction

        // Fixed-point quotient num*65536/den, truncated toward zero and saturated.
        function int qdiv(longint num, longint den);
            bit              neg;
            longint unsigned mag, d, q, rem;
            neg = num < 0;
            mag = neg ? longint'(-num) : num;
            d   = den;
            q   = mag / d;
            rem = mag % d;
            if (q >= 32768) return neg ? 32'sh80000000 : 32'sh7fffffff;
            for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q   = q | 1;
                end
            end
            return neg ? -int'(q) : int'(q);
        endfunction

        function void predict_fit();
            int              n, p, sweeps, nb, bj, x, r;
            int              coef[16], prev[16];
            longint          pred[1024];
            longint          zs, rs, z, rho, num, lam, d;
            longint unsigned change, m;
            bit              conv;
            t_out_item       res;
            n = (rows_cfg == 0) ? 1 : ((rows_cfg > 1024) ? 1024 : rows_cfg);
            p = (cols_cfg == 0) ? 1 : ((cols_cfg > 16) ? 16 : cols_cfg);
            lam = lambda_q;
            foreach (coef[k]) coef[k] = 0;
            foreach (pred[i]) pred[i] = 0;
            sweeps = 0;
            conv = 0;
            for (int it = 0; it < iter_max; it++) begin
                prev = coef;
                for (int j = 0; j < p; j++) begin
                    bj = coef[j];
                    zs = 0;
                    rs = 0;
                    for (int i = 0; i < n; i++) begin
                        x  = mat_mem[i * 16 + j];
                        r  = sat32(longint'(tgt_mem[i]) - (pred[i] - qmul(x, bj)));
                        zs += qmul(x, x);
                        rs += qmul(x, r);
                    end
                    z   = zs / n;
                    rho = rs / n;
                    if (j == 0) num = rho;
                    else if (rho > lam) num = rho - lam;
                    else if (rho < -lam) num = rho + lam;
                    else num = 0;
                    nb = (z == 0 || num == 0) ? 0 : qdiv(num, z);
                    if (nb != bj) begin
                        for (int i = 0; i < n; i++) begin
                            x = mat_mem[i * 16 + j];
                            pred[i] += qmul(x, nb) - qmul(x, bj);
                        end
                        coef[j] = nb;
                    end
                end
                sweeps++;
                change = 0;
                for (int k = 0; k < p; k++) begin
                    d = longint'(coef[k]) - longint'(prev[k]);
                    m = (d < 0) ? longint'(-d) : d;
                    change += (m * m) >> 16;
                end
                if (change < tol_q) begin
                    conv = 1;
                    break;
                end
            end
            for (int k = 0; k < p; k++) begin
                res.coef_index  = 4'(k);
                res.coef_value  = coef[k];
                res.last        = (k == p - 1);
                res.sweeps_used = 16'(sweeps);
                res.converged   = conv;
                coef_expect_q   = {coef_expect_q, res};
            end
        endfunction

        function void note_item(t_in_item it);
            case (it.opcode)
                OP_MAT: mat_mem[{it.row, it.col}] = it.value;
                OP_TGT: tgt_mem[it.row] = it.value;
                OP_RUN: predict_fit();
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (coef_expect_q.size() == 0) begin
                $error("unexpected coefficient result, index %0d", got.coef_index);
                errors++;
                return;
            end
            want = coef_expect_q.pop_front();
            if (got.coef_index !== want.coef_index) begin
                $error("coef_index: expected %0d, got %0d", want.coef_index, got.coef_index);
                errors++;
            end
            if (got.coef_value !== want.coef_value) begin
                $error("coef_value: expected %0d, got %0d", want.coef_value, got.coef_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (got.sweeps_used !== want.sweeps_used) begin
                $error("sweeps_used: expected %0d, got %0d", want.sweeps_used,
                       got.sweeps_used);
                errors++;
            end
            if (got.converged !== want.converged) begin
                $error("converged: expected %0d, got %0d", want.converged, got.converged);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_item              i_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_res_valid;
    t_out_item             o_res;

    fit_scoreboard sb = new();
    int            items_sent = 0;
    bit            quiet = 0;

    lasso_coordinate_descent dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            sb.check_result(o_res);
        end
    end

    // Holds start high until the item is taken; the caller follows with another
    // send, an idle stretch or a drain in the same step.
    task automatic send(logic [1:0] op, logic [9:0] row, logic [3:0] col, logic [31:0] val);
        t_in_item it;
        it.opcode = op;
        it.row    = row;
        it.col    = col;
        it.value  = val;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic idle(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 3) == 0) idle($urandom_range(1, 8));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves the write enable high; a group of writes ends with cfg_end.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic cfg_end();
        i_cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(logic [30:0] lam, logic [30:0] tol, logic [15:0] iters,
                           logic [10:0] rows, logic [4:0] cols);
        cfg_write(CFG_LAMBDA, lam);
        cfg_write(CFG_TOLERANCE, tol);
        cfg_write(CFG_MAX_ITER, 31'(iters));
        cfg_write(CFG_ROW_COUNT, 31'(rows));
        cfg_write(CFG_COL_COUNT, 31'(cols));
        cfg_end();
    endtask

    function automatic logic [31:0] rand_value();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h80000) - 32'h40000;
        return $urandom;
    endfunction

    initial begin
        int rows, cols, n_eff, p_eff;
        logic [30:0] lam, tol;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every entry of the rows in use, so no fit reads an unwritten entry.
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 16; c++) send(OP_MAT, 10'(r), 4'(c), rand_value());
            send(OP_TGT, 10'(r), 4'd0, rand_value());
        end
        drain();

        // Zero row and column counts act as one; extreme target and lambda zero.
        cfg_write(CFG_UNUSED, 31'h7fffffff);
        cfg_all(31'd0, 31'd7, 16'd1, 11'd0, 5'd0);
        send(OP_MAT, 0, 0, 32'h00010000);
        send(OP_TGT, 0, 0, 32'h7fffffff);
        send(OP_RUN, 0, 0, 0);
        drain();

        // Most negative values with the largest penalty, plus an unused opcode.
        cfg_all(31'h7fffffff, 31'd7, 16'd4, 11'd2, 5'd2);
        send(OP_MAT, 0, 0, 32'h80000000);
        send(OP_MAT, 0, 1, 32'h80000000);
        send(OP_MAT, 1, 0, 32'h7fffffff);
        send(OP_MAT, 1, 1, 32'h00020000);
        send(OP_TGT, 0, 0, 32'h80000000);
        send(OP_TGT, 1, 15, 32'h00030000);
        send(OP_NONE, 10'h3ff, 4'hf, 32'hffffffff);
        send(OP_MAT, 1023, 15, 32'h12345678);
        send(OP_RUN, 0, 0, 0);
        drain();

        // A column with zero energy.
        cfg_all(31'd0, 31'd7, 16'd3, 11'd2, 5'd2);
        send(OP_MAT, 0, 1, 0);
        send(OP_MAT, 1, 1, 0);
        send(OP_RUN, 0, 0, 0);
        drain();

        // No sweeps at all.
        cfg_write(CFG_MAX_ITER, 31'd0);
        cfg_end();
        send(OP_RUN, 0, 0, 0);
        drain();

        // Widest tolerance with the iteration limit at its top: stops early.
        cfg_all(31'd65536, 31'h7fffffff, 16'hffff, 11'd1, 5'd1);
        send(OP_RUN, 0, 0, 0);
        drain();

        // Zero tolerance never converges.
        cfg_all(31'd1000, 31'd0, 16'd3, 11'd3, 5'd4);
        send(OP_RUN, 0, 0, 0);
        drain();

        // A column count above the store width saturates.
        cfg_all(31'd65536, 31'd7, 16'd1, 11'd4, 5'd31);
        send(OP_RUN, 0, 0, 0);
        drain();

        while (items_sent < 470) begin
            if (items_sent > 400) quiet = 1;
            case ($urandom_range(0, 3))
                0: lam = 0;
                1: lam = 31'($urandom_range(0, 131072));
                2: lam = 31'h7fffffff;
                default: lam = 31'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: tol = 0;
                1: tol = 7;
                2: tol = 31'($urandom_range(0, 65536));
                default: tol = 31'($urandom);
            endcase
            rows = $urandom_range(0, 4);
            cols = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
            cfg_all(lam, tol, 16'($urandom_range(0, 8)), 11'(rows), 5'(cols));
            n_eff = (rows == 0) ? 1 : rows;
            p_eff = (cols == 0) ? 1 : ((cols > 16) ? 16 : cols);

            // Mostly a fresh data set for the rows and columns in use.
            if ($urandom_range(0, 4) != 0) begin
                for (int r = 0; r < n_eff; r++) begin
                    send(OP_TGT, 10'(r), 4'($urandom), rand_value());
                    maybe_idle();
                    for (int c = 0; c < p_eff; c++) begin
                        send(OP_MAT, 10'(r), 4'(c), rand_value());
                        maybe_idle();
                    end
                end
            end
            repeat ($urandom_range(0, 3)) begin
                send($urandom_range(0, 3) == 0 ? OP_NONE : 2'($urandom_range(0, 1)),
                     10'($urandom), 4'($urandom), $urandom);
                maybe_idle();
            end
            send(OP_RUN, 10'($urandom), 4'($urandom), $urandom);
            maybe_idle();
            if ($urandom_range(0, 3) == 0) begin
                send(OP_RUN, 0, 0, 0);
                maybe_idle();
            end
            drain();
        end

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
